// ===== sv/pbc_pkg.sv =====
`timescale 1ns / 1ps

package pbc_pkg;

   localparam int PixelWidth = 32;
   localparam int ByteWidth  = 8;
   localparam int CsrAddrWidth = 2;
   localparam int CsrDataWidth = 32;
   localparam int ReqDataWidth = 64;
   localparam int RspDataWidth = 32;

   localparam logic [ByteWidth-1:0] ByteMax = 8'hff;

   // register indexes on the csr port
   localparam logic [CsrAddrWidth-1:0] CSR_OP_MODE       = 2'd0;
   localparam logic [CsrAddrWidth-1:0] CSR_SOURCE_FORMAT = 2'd1;
   localparam logic [CsrAddrWidth-1:0] CSR_FILL_COLOR    = 2'd2;

   // op_mode codes
   localparam logic [1:0] OP_TEXTURE = 2'd0;
   localparam logic [1:0] OP_FILL    = 2'd1;
   localparam logic [1:0] OP_REPLACE = 2'd2;

   // source_format codes
   localparam logic [2:0] FMT_RGB8  = 3'd0;
   localparam logic [2:0] FMT_RGBA8 = 3'd1;
   localparam logic [2:0] FMT_Y8    = 3'd2;
   localparam logic [2:0] FMT_YA8   = 3'd3;
   localparam logic [2:0] FMT_A8    = 3'd4;

   localparam logic [1:0]            OpModeReset       = OP_TEXTURE;
   localparam logic [2:0]            SourceFormatReset = FMT_RGBA8;
   localparam logic [PixelWidth-1:0] FillColorReset    = 32'hffff_ffff;

   typedef struct packed {
      logic [1:0]            op_mode;
      logic [2:0]            source_format;
      logic [PixelWidth-1:0] fill_color;
   } cfg_type;

   typedef struct packed {
      logic [ByteWidth-1:0]  src_byte_3;
      logic [ByteWidth-1:0]  src_byte_2;
      logic [ByteWidth-1:0]  src_byte_1;
      logic [ByteWidth-1:0]  src_byte_0;
      logic [PixelWidth-1:0] dest_pixel;
   } pix_in_type;

   typedef struct packed {
      logic                  written;
      logic [PixelWidth-1:0] new_pixel;
   } pix_out_type;

   // (d*(255-a) + s*a) >> 8, never above 254
   function automatic logic [ByteWidth-1:0] blend_ch(input logic [ByteWidth-1:0] d,
                                                      input logic [ByteWidth-1:0] s,
                                                      input logic [ByteWidth-1:0] a);
      logic [2*ByteWidth-1:0] sum;
      logic [ByteWidth-1:0]   inv;
      inv = ByteMax - a;
      sum = ({{ByteWidth{1'b0}}, d} * {{ByteWidth{1'b0}}, inv})
          + ({{ByteWidth{1'b0}}, s} * {{ByteWidth{1'b0}}, a});
      return sum[2*ByteWidth-1:ByteWidth];
   endfunction

endpackage

// ===== sv/pbc_csr.sv =====
`timescale 1ns / 1ps

module pbc_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [pbc_pkg::CsrAddrWidth-1:0]    csr_addr,
   input  logic [pbc_pkg::CsrDataWidth-1:0]    csr_wdata,
   output pbc_pkg::cfg_type                    cfg
);

   pbc_pkg::cfg_type cfg_ff;
   pbc_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_addr)
            pbc_pkg::CSR_OP_MODE:       cfg_in.op_mode       = csr_wdata[1:0];
            pbc_pkg::CSR_SOURCE_FORMAT: cfg_in.source_format = csr_wdata[2:0];
            pbc_pkg::CSR_FILL_COLOR:    cfg_in.fill_color    = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.op_mode       <= pbc_pkg::OpModeReset;
         cfg_ff.source_format <= pbc_pkg::SourceFormatReset;
         cfg_ff.fill_color    <= pbc_pkg::FillColorReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== sv/pbc_blend.sv =====
`timescale 1ns / 1ps

module pbc_blend (
   input  pbc_pkg::cfg_type    cfg,
   input  pbc_pkg::pix_in_type pix,
   output pbc_pkg::pix_out_type res
);

   logic [7:0] dst_r, dst_g, dst_b, dst_a;
   logic [7:0] src_r, src_g, src_b, src_a;
   logic [7:0] bl_r, bl_g, bl_b;
   logic [8:0] alpha_sum;
   logic [7:0] alpha_sat;
   logic [7:0] fc_r, fc_g, fc_b, fc_a;

   assign dst_r = pix.dest_pixel[7:0];
   assign dst_g = pix.dest_pixel[15:8];
   assign dst_b = pix.dest_pixel[23:16];
   assign dst_a = pix.dest_pixel[31:24];

   assign fc_r = cfg.fill_color[31:24];
   assign fc_g = cfg.fill_color[23:16];
   assign fc_b = cfg.fill_color[15:8];
   assign fc_a = cfg.fill_color[7:0];

   // one shared set of channel blenders: fill colour or texel feeds it
   always_comb begin
      if (cfg.op_mode == pbc_pkg::OP_FILL) begin
         src_r = fc_r;
         src_g = fc_g;
         src_b = fc_b;
         src_a = fc_a;
      end else if (cfg.source_format == pbc_pkg::FMT_YA8) begin
         src_r = pix.src_byte_0;
         src_g = pix.src_byte_0;
         src_b = pix.src_byte_0;
         src_a = pix.src_byte_1;
      end else begin
         src_r = pix.src_byte_0;
         src_g = pix.src_byte_1;
         src_b = pix.src_byte_2;
         src_a = pix.src_byte_3;
      end
   end

   assign bl_r = pbc_pkg::blend_ch(dst_r, src_r, src_a);
   assign bl_g = pbc_pkg::blend_ch(dst_g, src_g, src_a);
   assign bl_b = pbc_pkg::blend_ch(dst_b, src_b, src_a);

   assign alpha_sum = {1'b0, dst_a} + {1'b0, src_a};
   assign alpha_sat = alpha_sum[8] ? pbc_pkg::ByteMax : alpha_sum[7:0];

   always_comb begin
      res.new_pixel = pix.dest_pixel;
      res.written   = 1'b0;
      unique case (cfg.op_mode)
         pbc_pkg::OP_TEXTURE: begin
            unique case (cfg.source_format)
               pbc_pkg::FMT_RGB8: begin
                  res.new_pixel = {pbc_pkg::ByteMax, pix.src_byte_2, pix.src_byte_1,
                                   pix.src_byte_0};
                  res.written   = 1'b1;
               end
               pbc_pkg::FMT_Y8, pbc_pkg::FMT_A8: begin
                  res.new_pixel = {pbc_pkg::ByteMax, pix.src_byte_0, pix.src_byte_0,
                                   pix.src_byte_0};
                  res.written   = 1'b1;
               end
               pbc_pkg::FMT_RGBA8, pbc_pkg::FMT_YA8: begin
                  if (src_a == pbc_pkg::ByteMax) begin
                     res.new_pixel = {pbc_pkg::ByteMax, src_b, src_g, src_r};
                     res.written   = 1'b1;
                  end else if (src_a != 8'd0) begin
                     res.new_pixel = {pbc_pkg::ByteMax, bl_b, bl_g, bl_r};
                     res.written   = 1'b1;
                  end
               end
               default: ;
            endcase
         end
         pbc_pkg::OP_FILL: begin
            // blended channels stay below 255, so only the alpha add saturates
            if (src_a == pbc_pkg::ByteMax) begin
               res.new_pixel = {src_a, src_b, src_g, src_r};
               res.written   = 1'b1;
            end else if (src_a != 8'd0) begin
               res.new_pixel = {alpha_sat, bl_b, bl_g, bl_r};
               res.written   = 1'b1;
            end
         end
         pbc_pkg::OP_REPLACE: begin
            if (pix.src_byte_0 != 8'd0) begin
               res.new_pixel = {fc_a, fc_b, fc_g, fc_r};
               res.written   = 1'b1;
            end
         end
         default: ;
      endcase
   end

endmodule

// ===== sv/pixel_blend_compositor.sv =====
`timescale 1ns / 1ps
// a req transfer loads the input register, and the result register behind it drives rsp_tvalid
// throughput: one pixel per cycle while rsp_tready stays high; a stalled rsp word backs up into req_tready
// the blend datapath between them is two 8x8 products and a sum per channel
// reset: synchronous, active high; clears both valid flags and loads the csr reset values
// (op_mode texture, source_format rgba8, fill_color all ones)

module pixel_blend_compositor (
   input  logic                              clock,
   input  logic                              reset,
   // request stream
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // dest_pixel[31:0], src_byte_0[39:32], src_byte_1[47:40], src_byte_2[55:48],
   // src_byte_3[63:56]
   input  logic [pbc_pkg::ReqDataWidth-1:0]  req_tdata,
   // response stream
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // new_pixel[31:0]
   output logic [pbc_pkg::RspDataWidth-1:0]  rsp_tdata,
   // written[0]
   output logic [0:0]                        rsp_tuser,
   // register writes
   input  logic                              csr_we,
   input  logic [pbc_pkg::CsrAddrWidth-1:0]  csr_addr,
   input  logic [pbc_pkg::CsrDataWidth-1:0]  csr_wdata
);

   pbc_pkg::cfg_type     cfg;
   pbc_pkg::pix_in_type  pix_ff;
   pbc_pkg::pix_out_type blend_res;
   pbc_pkg::pix_out_type rsp_ff;
   logic                 pix_vld_ff;
   logic                 pix_vld_in;
   logic                 rsp_vld_ff;
   logic                 rsp_vld_in;
   logic                 rsp_open;
   logic                 pix_move;
   logic                 req_take;

   // csr block; write only while the pipe is empty, the block itself does not enforce this
   pbc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // result register can load when empty or when its word leaves this cycle
   assign rsp_open   = !rsp_vld_ff || rsp_tready;
   // input register hands its pixel on whenever the result register opens
   assign pix_move   = pix_vld_ff && rsp_open;
   assign req_tready = !pix_vld_ff || rsp_open;
   assign req_take   = req_tvalid && req_tready;

   assign pix_vld_in = req_take || (pix_vld_ff && !rsp_open);
   assign rsp_vld_in = pix_move || (rsp_vld_ff && !rsp_tready);

   // control flags
   always_ff @(posedge clock) begin
      if (reset) begin
         pix_vld_ff <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         pix_vld_ff <= pix_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   // input register: capture on every request transfer
   always_ff @(posedge clock) begin
      if (req_take) begin
         pix_ff <= pbc_pkg::pix_in_type'(req_tdata);
      end
   end

   // single pass compositing of the held pixel
   pbc_blend u_blend (
      .cfg (cfg),
      .pix (pix_ff),
      .res (blend_res)
   );

   // result register
   always_ff @(posedge clock) begin
      if (pix_move) begin
         rsp_ff <= blend_res;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_ff.new_pixel;
   assign rsp_tuser  = rsp_ff.written;

endmodule

// ===== sim/tb_pixel_blend_compositor.sv =====
`timescale 1ns / 1ps

module tb_pixel_blend_compositor;

   import pbc_pkg::*;

   // codes the block ignores, no package name exists for them
   localparam logic [1:0] OP_UNUSED   = 2'd3;
   localparam logic [2:0] FMT_RSVD_LO = 3'd5;
   localparam logic [2:0] FMT_RSVD_HI = 3'd7;

   localparam logic [ByteWidth-1:0] ALPHA_CLEAR = 8'h00;

   localparam int CycleLimit   = 400000;
   localparam int SettleCycles = 6;      // pipeline is two deep, a few extra for margin
   localparam int LongHold     = 400;    // countdown start for the receiver's long hold
   localparam int RandPhases   = 12;
   localparam int RandPerPhase = 46;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;

   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [ReqDataWidth-1:0] req_tdata = '0;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RspDataWidth-1:0] rsp_tdata;
   logic [0:0]              rsp_tuser;
   logic                    csr_we = 1'b0;
   logic [CsrAddrWidth-1:0] csr_addr = '0;
   logic [CsrDataWidth-1:0] csr_wdata = '0;

   pixel_blend_compositor uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always #2 clock = ~clock;

   // register copy used by the pixel predictor, updated as each csr write goes out
   cfg_type cfg_shadow = '{op_mode: OpModeReset, source_format: SourceFormatReset,
                           fill_color: FillColorReset};

   pix_in_type  pixel_feed_q[$];     // pixels waiting to be offered on req
   pix_out_type blend_result_q[$];   // predicted rsp words, oldest first

   int errors         = 0;
   int pixels_sent    = 0;
   int pixels_checked = 0;
   int pixels_stored  = 0;
   int settings_used  = 1;
   int mode_hits[4]   = '{0, 0, 0, 0};

   // ---------------------------------------------------------------------------
   // pixel predictor
   // ---------------------------------------------------------------------------

   // one channel of the alpha mix, (d*(255-a) + s*a) >> 8
   function automatic logic [7:0] mix_channel(input logic [7:0] d, input logic [7:0] s,
                                              input logic [7:0] a);
      int unsigned acc;
      acc = int'(d) * (255 - int'(a)) + int'(s) * int'(a);
      return 8'(acc >> 8);
   endfunction

   // texel over destination: skip when clear, copy when opaque, else mix to opaque
   function automatic pix_out_type texel_over(input logic [31:0] dst, input logic [7:0] r,
                                              input logic [7:0] g, input logic [7:0] b,
                                              input logic [7:0] a);
      pix_out_type o;
      o.new_pixel = dst;
      o.written   = 1'b0;
      if (a == ByteMax) begin
         o.new_pixel = {ByteMax, b, g, r};
         o.written   = 1'b1;
      end else if (a != ALPHA_CLEAR) begin
         o.new_pixel = {ByteMax, mix_channel(dst[23:16], b, a),
                        mix_channel(dst[15:8], g, a), mix_channel(dst[7:0], r, a)};
         o.written   = 1'b1;
      end
      return o;
   endfunction

   function automatic pix_out_type predict_pixel(input cfg_type c, input pix_in_type p);
      pix_out_type o;
      logic [7:0]  fr, fg, fb, fa;
      int unsigned alpha_sum;
      fr = c.fill_color[31:24];
      fg = c.fill_color[23:16];
      fb = c.fill_color[15:8];
      fa = c.fill_color[7:0];
      o.new_pixel = p.dest_pixel;
      o.written   = 1'b0;
      case (c.op_mode)
         OP_TEXTURE: begin
            case (c.source_format)
               FMT_RGB8: begin
                  o.new_pixel = {ByteMax, p.src_byte_2, p.src_byte_1, p.src_byte_0};
                  o.written   = 1'b1;
               end
               FMT_RGBA8: o = texel_over(p.dest_pixel, p.src_byte_0, p.src_byte_1,
                                         p.src_byte_2, p.src_byte_3);
               FMT_Y8, FMT_A8: begin
                  o.new_pixel = {ByteMax, p.src_byte_0, p.src_byte_0, p.src_byte_0};
                  o.written   = 1'b1;
               end
               FMT_YA8: o = texel_over(p.dest_pixel, p.src_byte_0, p.src_byte_0,
                                       p.src_byte_0, p.src_byte_1);
               default: ;
            endcase
         end
         OP_FILL: begin
            if (fa == ByteMax) begin
               o.new_pixel = {fa, fb, fg, fr};
               o.written   = 1'b1;
            end else if (fa != ALPHA_CLEAR) begin
               // destination alpha accumulates and clips at full
               alpha_sum   = int'(p.dest_pixel[31:24]) + int'(fa);
               o.new_pixel = {(alpha_sum > 255) ? ByteMax : 8'(alpha_sum),
                              mix_channel(p.dest_pixel[23:16], fb, fa),
                              mix_channel(p.dest_pixel[15:8], fg, fa),
                              mix_channel(p.dest_pixel[7:0], fr, fa)};
               o.written   = 1'b1;
            end
         end
         OP_REPLACE: begin
            if (p.src_byte_0 != 8'h00) begin
               o.new_pixel = {fa, fb, fg, fr};
               o.written   = 1'b1;
            end
         end
         default: ;
      endcase
      return o;
   endfunction

   // ---------------------------------------------------------------------------
   // req driver: bursts of random length, random gaps in between
   // ---------------------------------------------------------------------------
   pix_in_type drv_pixel;
   int         burst_left = 0;
   int         gap_left   = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         burst_left = 0;
         gap_left   = 0;
      end else begin
         // the pixel on the bus moved this edge, predict what comes back
         if (req_tvalid && req_tready) begin
            blend_result_q.push_back(predict_pixel(cfg_shadow, drv_pixel));
            mode_hits[cfg_shadow.op_mode]++;
            pixels_sent++;
         end
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else if (pixel_feed_q.size() > 0) begin
               drv_pixel = pixel_feed_q.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= drv_pixel;
               if (burst_left <= 1) begin
                  burst_left = $urandom_range(1, 24);
                  // a quarter of the bursts run straight into the next one
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
               end else begin
                  burst_left--;
               end
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------------
   // rsp receiver: stall pattern redrawn on a countdown, plus one long hold on request
   // ---------------------------------------------------------------------------
   int rsp_mode        = 0;
   int rsp_mode_cnt    = 0;
   int long_hold_req   = 0;   // bumped by the stimulus to ask for a long hold
   int long_hold_ack   = 0;
   int long_hold_left  = 0;
   int long_holds_done = 0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_mode_cnt == 0) begin
            rsp_mode     = $urandom_range(0, 3);
            rsp_mode_cnt = 32;
         end
         rsp_mode_cnt--;
         if (long_hold_left > 0) begin
            long_hold_left--;
            rsp_tready <= 1'b0;
         end else if (long_hold_req != long_hold_ack) begin
            long_hold_ack  = long_hold_req;
            long_hold_left = LongHold;
            long_holds_done++;
            rsp_tready <= 1'b0;
         end else begin
            case (rsp_mode)
               0:       rsp_tready <= 1'b1;                          // never stalls
               1:       rsp_tready <= ($urandom_range(0, 1) == 0);
               2:       rsp_tready <= ($urandom_range(0, 7) != 0);
               default: rsp_tready <= ($urandom_range(0, 3) == 0);   // mostly stalled
            endcase
         end
      end
   end

   // ---------------------------------------------------------------------------
   // rsp monitor: every transfer against the oldest prediction
   // ---------------------------------------------------------------------------
   pix_out_type want;

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (blend_result_q.size() == 0) begin
            errors++;
            $display("%0t: rsp transfer with nothing expected, new_pixel %h written %b",
                     $time, rsp_tdata, rsp_tuser[0]);
         end else begin
            want = blend_result_q.pop_front();
            pixels_checked++;
            if (want.written) pixels_stored++;
            if (rsp_tdata !== want.new_pixel) begin
               errors++;
               $display("%0t: new_pixel expected %h actual %h", $time, want.new_pixel,
                        rsp_tdata);
            end
            if (rsp_tuser[0] !== want.written) begin
               errors++;
               $display("%0t: written expected %b actual %b", $time, want.written,
                        rsp_tuser[0]);
            end
         end
      end
   end

   // ---------------------------------------------------------------------------
   // watchdog
   // ---------------------------------------------------------------------------
   int cycle_count = 0;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CycleLimit) begin
         $display("timeout after %0d cycles, %0d predictions outstanding", cycle_count,
                  blend_result_q.size());
         $display("tb_pixel_blend_compositor failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------
   // stimulus
   // ---------------------------------------------------------------------------
   task automatic add_pixel(input logic [31:0] dst, input logic [7:0] s0,
                            input logic [7:0] s1, input logic [7:0] s2,
                            input logic [7:0] s3);
      pix_in_type p;
      p.dest_pixel = dst;
      p.src_byte_0 = s0;
      p.src_byte_1 = s1;
      p.src_byte_2 = s2;
      p.src_byte_3 = s3;
      pixel_feed_q.push_back(p);
   endtask

   // sampled on the falling edge so the posedge processes have all settled
   task automatic wait_drained();
      do @(negedge clock);
      while (pixel_feed_q.size() != 0 || req_tvalid || blend_result_q.size() != 0);
      repeat (SettleCycles) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CsrAddrWidth-1:0] addr,
                            input logic [CsrDataWidth-1:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= value;
      case (addr)
         CSR_OP_MODE:       cfg_shadow.op_mode       = value[1:0];
         CSR_SOURCE_FORMAT: cfg_shadow.source_format = value[2:0];
         CSR_FILL_COLOR:    cfg_shadow.fill_color    = value;
         default: ;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // only called once the pipeline has drained
   task automatic set_config(input logic [1:0] mode, input logic [2:0] fmt,
                             input logic [31:0] color);
      write_reg(CSR_OP_MODE, 32'(mode));
      write_reg(CSR_SOURCE_FORMAT, 32'(fmt));
      write_reg(CSR_FILL_COLOR, color);
      settings_used++;
   endtask

   logic [1:0]  r_mode;
   logic [2:0]  r_fmt;
   logic [31:0] r_color;
   logic [31:0] r_dst;
   logic [7:0]  r_s0, r_s1, r_s2, r_s3;
   int          pick;

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // reset setting: texture rgba8, alpha clear / opaque / barely there / almost full
      add_pixel(32'h0000_0000, 8'hff, 8'hff, 8'hff, 8'h00);
      add_pixel(32'hffff_ffff, 8'h00, 8'h00, 8'h00, 8'hff);
      add_pixel(32'hffff_ffff, 8'h00, 8'h80, 8'hff, 8'h01);
      add_pixel(32'h1234_5678, 8'hff, 8'h00, 8'h80, 8'hfe);
      wait_drained();

      // opaque formats always write
      set_config(OP_TEXTURE, FMT_RGB8, 32'h0000_0000);
      add_pixel(32'h0000_0000, 8'hff, 8'h00, 8'h80, 8'h00);
      wait_drained();
      set_config(OP_TEXTURE, FMT_Y8, 32'h0000_0000);
      add_pixel(32'hffff_ffff, 8'h00, 8'hff, 8'hff, 8'hff);
      wait_drained();

      // gray with alpha: clear, opaque, partial
      set_config(OP_TEXTURE, FMT_YA8, 32'h0000_0000);
      add_pixel(32'h8080_8080, 8'hff, 8'h00, 8'h55, 8'haa);
      add_pixel(32'h0000_0000, 8'hc3, 8'hff, 8'h00, 8'h00);
      add_pixel(32'hffff_ffff, 8'h00, 8'h7f, 8'hff, 8'hff);
      wait_drained();

      // a8 is taken as gray
      set_config(OP_TEXTURE, FMT_A8, 32'h0000_0000);
      add_pixel(32'h00ff_00ff, 8'ha5, 8'h00, 8'h00, 8'h00);
      wait_drained();

      // reserved formats leave the pixel alone
      set_config(OP_TEXTURE, FMT_RSVD_LO, 32'h0000_0000);
      add_pixel(32'hcafe_f00d, 8'hff, 8'hff, 8'hff, 8'hff);
      wait_drained();
      set_config(OP_TEXTURE, FMT_RSVD_HI, 32'h0000_0000);
      add_pixel(32'h0f0f_0f0f, 8'h12, 8'h34, 8'h56, 8'h78);
      wait_drained();

      // fill: opaque colour, clear colour, partial with alpha clipping, faintest alpha
      set_config(OP_FILL, FMT_RGBA8, 32'h1122_33ff);
      add_pixel(32'h0000_0000, 8'h00, 8'h00, 8'h00, 8'h00);
      wait_drained();
      set_config(OP_FILL, FMT_RGBA8, 32'h0000_0000);
      add_pixel(32'hdead_beef, 8'hff, 8'hff, 8'hff, 8'hff);
      wait_drained();
      set_config(OP_FILL, FMT_RGBA8, 32'hff80_0080);
      add_pixel(32'hf010_2030, 8'h00, 8'h00, 8'h00, 8'h00);
      wait_drained();
      set_config(OP_FILL, FMT_RGBA8, 32'h00ff_7f01);
      add_pixel(32'hffff_ffff, 8'h00, 8'h00, 8'h00, 8'h00);
      wait_drained();

      // replace: zero mask skips, any nonzero mask writes
      set_config(OP_REPLACE, FMT_RGBA8, 32'ha1b2_c3d4);
      add_pixel(32'h0123_4567, 8'h00, 8'hff, 8'hff, 8'hff);
      add_pixel(32'h0123_4567, 8'h01, 8'h00, 8'h00, 8'h00);
      add_pixel(32'hffff_ffff, 8'hff, 8'h00, 8'h00, 8'h00);
      wait_drained();

      // the unused op mode passes everything through
      set_config(OP_UNUSED, FMT_RSVD_HI, 32'hffff_ffff);
      add_pixel(32'h89ab_cdef, 8'hff, 8'hff, 8'hff, 8'hff);
      wait_drained();

      // random settings, each followed by a batch of random pixels
      for (int ph = 0; ph < RandPhases; ph++) begin
         pick   = $urandom_range(0, 9);
         r_mode = (pick < 5) ? OP_TEXTURE : (pick < 7) ? OP_FILL :
                  (pick < 9) ? OP_REPLACE : OP_UNUSED;
         pick   = $urandom_range(0, 9);
         r_fmt  = (pick < 8) ? 3'(pick % 5) : 3'($urandom_range(5, 7));
         r_color = $urandom();
         // fill alpha mostly lands on its edge cases
         case ($urandom_range(0, 4))
            0: r_color[7:0] = ALPHA_CLEAR;
            1: r_color[7:0] = ByteMax;
            2: r_color[7:0] = 8'h01;
            3: r_color[7:0] = 8'hfe;
            default: ;
         endcase
         set_config(r_mode, r_fmt, r_color);

         // one batch runs into a receiver that holds off for a long time,
         // the pipeline fills and req_tready has to drop
         if (ph == 2) long_hold_req++;

         for (int n = 0; n < RandPerPhase; n++) begin
            r_dst = $urandom();
            r_s0  = 8'($urandom());
            r_s1  = 8'($urandom());
            r_s2  = 8'($urandom());
            r_s3  = 8'($urandom());
            case ($urandom_range(0, 7))
               0: begin r_s1 = ALPHA_CLEAR; r_s3 = ALPHA_CLEAR; end
               1: begin r_s1 = ByteMax;     r_s3 = ByteMax;     end
               2: r_s0 = 8'h00;   // replace mask off
               3: begin r_s1 = 8'h01; r_s3 = 8'hfe; end
               default: ;
            endcase
            add_pixel(r_dst, r_s0, r_s1, r_s2, r_s3);
         end
         wait_drained();
      end

      if (blend_result_q.size() != 0) begin
         errors++;
         $display("%0t: %0d predicted results never came out", $time, blend_result_q.size());
      end

      $display("%0d pixels checked over %0d register settings, %0d stored and %0d left as is",
               pixels_checked, settings_used, pixels_stored, pixels_checked - pixels_stored);
      $display("texture %0d, fill %0d, replace %0d, unused mode %0d; long rsp holds %0d",
               mode_hits[0], mode_hits[1], mode_hits[2], mode_hits[3], long_holds_done);
      if (errors == 0) begin
         $display("tb_pixel_blend_compositor passed");
      end else begin
         $display("tb_pixel_blend_compositor failed");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
sv/pbc_pkg.sv
sv/pbc_csr.sv
sv/pbc_blend.sv
sv/pixel_blend_compositor.sv
sim/tb_pixel_blend_compositor.sv
